[rtl/ncpc_pkg.sv]
// Shared types and constants for the nearest-centroid pixel classifier.
package ncpc_pkg;

    localparam int CHAN_W      = 8;
    localparam int SQ_W        = 16;
    localparam int DIST_W      = 18;
    localparam int LABEL_W     = 10;
    localparam int IN_IDX_W    = 10;
    localparam int COUNT_W     = 11;
    localparam int CELL_BITS   = 2;
    localparam int NUM_CELLS   = 1 << CELL_BITS;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 32;

    localparam logic [DIST_W-1:0] MAX_DIST = 18'd195075;

    localparam logic [CFG_ADDR_W-3:0] REG_COUNT = 1'b0;

    typedef enum logic {
        OP_LOAD     = 1'b0,
        OP_CLASSIFY = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } ctl_t;

    typedef struct packed {
        logic              done;
        logic              valid;
        logic [DIST_W-1:0] score;
    } red_t;

endpackage

[rtl/nearest_centroid_pixel_classifier.sv]
// Top level: stream and APB ports, scan sequencer and the chain of classifier cells.
//
// Input stream s_*: s_tuser is the operation. A load transaction writes one BGR centroid
// into entry entry_index (ignored if not below NUM_CENTROIDS) while the block stays idle. A
// classify transaction searches entries 0 .. centroids_in_use-1 and gives one result on
// m_*: the index of the nearest centroid (lowest index on a tie) and its squared distance.
// Load transactions give no result. Every entry searched must have been loaded before.
// The table is interleaved over four cells; each cycle the sequencer issues one row, so
// four centroids are compared per cycle as the row moves down the chain. A classify
// transaction searches count entries, count being centroids_in_use clamped to 1 ..
// NUM_CENTROIDS. One item is handled at a time: s_tready is high only while the block
// is idle. A finished result sits in the output register while the next transaction is
// taken; if the receiver still holds off when the next result is ready, the block waits
// with s_tready low.
// Register 0 at address 0 (APB) holds centroids_in_use, reset NUM_CENTROIDS.
// Reset (aresetn low, synchronous) clears control state and sets the register back to
// NUM_CENTROIDS; the centroid table keeps undefined contents until loaded.
module nearest_centroid_pixel_classifier
    import ncpc_pkg::*;
#(
    parameter int NUM_CENTROIDS = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // entry_index, blue, green, red, zero pad
    input  logic [0:0]            s_tuser,   // operation
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // cluster_label, squared_distance, zero pad
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CNT_W      = $clog2(NUM_CENTROIDS + 1);
    localparam int WIDX_W     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int BANK_DEPTH = (NUM_CENTROIDS + NUM_CELLS - 1) / NUM_CELLS;
    localparam int ROW_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    state_t            state_reg, state_next;
    logic [WIDX_W-1:0] count_reg;
    logic [WIDX_W-1:0] count_eff_reg, count_eff;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ROW_W-1:0]  last_row_reg, last_row;
    pixel_t            pix_reg;
    logic [LABEL_W-1:0] res_label_reg;
    logic [DIST_W-1:0] res_dist_reg;
    logic              m_valid_reg, m_valid_next;
    logic [LABEL_W-1:0] m_label_reg;
    logic [DIST_W-1:0] m_dist_reg;

    op_t               s_op;
    logic [WIDX_W-1:0] s_idx;
    pixel_t            s_pix;
    logic              accept;
    logic              classify_go;
    logic              load_hit;
    logic              out_load;
    logic              cfg_wr;
    logic [WIDX_W-1:0] cfg_count;
    ctl_t              tok;

    ctl_t              chain_ctl [NUM_CELLS+1];
    logic [ROW_W-1:0]  chain_row [NUM_CELLS+1];
    pixel_t            chain_pix [NUM_CELLS+1];
    red_t              chain_red [NUM_CELLS+1];
    logic [WIDX_W-1:0] chain_idx [NUM_CELLS+1];

    // input decode
    assign s_op        = op_t'(s_tuser[0]);
    assign s_idx       = WIDX_W'(s_tdata[IN_IDX_W-1:0]);
    assign s_pix.blue  = s_tdata[IN_IDX_W +: CHAN_W];
    assign s_pix.green = s_tdata[IN_IDX_W + CHAN_W +: CHAN_W];
    assign s_pix.red   = s_tdata[IN_IDX_W + 2*CHAN_W +: CHAN_W];
    assign accept      = s_tvalid && s_tready;
    assign classify_go = accept && (s_op == OP_CLASSIFY);
    assign load_hit    = accept && (s_op == OP_LOAD) && (s_idx < WIDX_W'(NUM_CENTROIDS));

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[CFG_ADDR_W-1:2] == REG_COUNT);

    always_comb begin
        prdata = '0;
        if (paddr[CFG_ADDR_W-1:2] == REG_COUNT) begin
            prdata = CFG_DATA_W'(count_reg);
        end
    end

    // search length for the next classify transaction
    always_comb begin
        cfg_count = count_reg;
        if (cfg_count == '0) begin
            count_eff = WIDX_W'(1);
        end else if (cfg_count > WIDX_W'(NUM_CENTROIDS)) begin
            count_eff = WIDX_W'(NUM_CENTROIDS);
        end else begin
            count_eff = cfg_count;
        end
        last_row = ROW_W'((count_eff - WIDX_W'(1)) >> CELL_BITS);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (classify_go) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (row_reg == last_row_reg) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (chain_red[NUM_CELLS].done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready  = 1'b0;
        tok       = '0;
        out_load  = 1'b0;
        row_next  = row_reg;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                row_next = '0;
            end
            ST_SCAN: begin
                tok.valid = 1'b1;
                tok.first = (row_reg == '0);
                tok.last  = (row_reg == last_row_reg);
                row_next  = row_reg + ROW_W'(1);
            end
            ST_WAIT: begin
                row_next = '0;
            end
            ST_OUT: begin
                out_load = !m_valid_reg || m_tready;
            end
            default: begin
                row_next = '0;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= WIDX_W'(NUM_CENTROIDS);
            row_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr) begin
                count_reg <= WIDX_W'(pwdata[COUNT_W-1:0]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (classify_go) begin
            count_eff_reg <= count_eff;
            last_row_reg  <= last_row;
            pix_reg       <= s_pix;
        end
        if (chain_red[NUM_CELLS].done) begin
            res_label_reg <= chain_idx[NUM_CELLS][LABEL_W-1:0];
            res_dist_reg  <= chain_red[NUM_CELLS].score;
        end
        if (out_load) begin
            m_label_reg <= res_label_reg;
            m_dist_reg  <= res_dist_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({m_dist_reg, m_label_reg});

    // cell chain
    assign chain_ctl[0] = tok;
    assign chain_row[0] = row_reg;
    assign chain_pix[0] = pix_reg;
    assign chain_red[0] = '0;
    assign chain_idx[0] = '0;

    for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
        logic cell_wr;

        assign cell_wr = load_hit && (s_idx[CELL_BITS-1:0] == CELL_BITS'(c));

        ncpc_cell #(
            .CELL_ID    (c),
            .BANK_DEPTH (BANK_DEPTH),
            .ROW_W      (ROW_W),
            .WIDX_W     (WIDX_W)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .wr_en       (cell_wr),
            .wr_row      (s_idx[CELL_BITS +: ROW_W]),
            .wr_data     (s_pix),
            .count_in    (count_eff_reg),
            .ctl_in      (chain_ctl[c]),
            .row_in      (chain_row[c]),
            .pix_in      (chain_pix[c]),
            .red_in      (chain_red[c]),
            .red_idx_in  (chain_idx[c]),
            .ctl_out     (chain_ctl[c+1]),
            .row_out     (chain_row[c+1]),
            .pix_out     (chain_pix[c+1]),
            .red_out     (chain_red[c+1]),
            .red_idx_out (chain_idx[c+1])
        );
    end

    a_done_only_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        chain_red[NUM_CELLS].done |-> state_reg == ST_WAIT)
        else $error("chain result outside of wait state");

    a_done_then_out: assert property (@(posedge aclk) disable iff (!aresetn)
        chain_red[NUM_CELLS].done |=> state_reg == ST_OUT)
        else $error("chain result not taken to output");

    a_result_only_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result raised without a finished search");

    a_dist_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_dist_reg <= MAX_DIST)
        else $error("squared distance out of range");

endmodule

[rtl/ncpc_cell.sv]
// One classifier cell: a bank of centroids, a distance pipeline and a running best.
module ncpc_cell
    import ncpc_pkg::*;
#(
    parameter int CELL_ID    = 0,
    parameter int BANK_DEPTH = 256,
    parameter int ROW_W      = 8,
    parameter int WIDX_W     = 11
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [ROW_W-1:0]  wr_row,
    input  pixel_t            wr_data,
    input  logic [WIDX_W-1:0] count_in,
    input  ctl_t              ctl_in,
    input  logic [ROW_W-1:0]  row_in,
    input  pixel_t            pix_in,
    input  red_t              red_in,
    input  logic [WIDX_W-1:0] red_idx_in,
    output ctl_t              ctl_out,
    output logic [ROW_W-1:0]  row_out,
    output pixel_t            pix_out,
    output red_t              red_out,
    output logic [WIDX_W-1:0] red_idx_out
);

    pixel_t mem [BANK_DEPTH];

    ctl_t              ctl_out_reg;
    logic [ROW_W-1:0]  row_out_reg;
    pixel_t            pix_out_reg;

    pixel_t            rd_reg;
    ctl_t              s1_ctl_reg;
    logic              s1_hit_reg;
    logic [WIDX_W-1:0] s1_idx_reg;
    pixel_t            s1_pix_reg;

    ctl_t              s2_ctl_reg;
    logic              s2_hit_reg;
    logic [WIDX_W-1:0] s2_idx_reg;
    logic [SQ_W-1:0]   sq_b_reg, sq_g_reg, sq_r_reg;
    logic [SQ_W-1:0]   sq_b_next, sq_g_next, sq_r_next;

    logic              best_valid_reg, best_valid_next;
    logic [DIST_W-1:0] best_dist_reg, best_dist_next;
    logic [WIDX_W-1:0] best_idx_reg, best_idx_next;
    logic              s3_last_reg;

    red_t              red_out_reg, red_out_next;
    logic [WIDX_W-1:0] red_idx_out_reg, red_idx_out_next;

    logic [WIDX_W-1:0] entry_idx;
    logic [CHAN_W-1:0] d_b, d_g, d_r;
    logic [DIST_W-1:0] sum;
    logic              base_valid;
    logic              take_local;

    assign entry_idx = (WIDX_W'(row_in) << CELL_BITS) | WIDX_W'(CELL_ID);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_row] <= wr_data;
        end
        rd_reg <= mem[row_in];
    end

    // absolute channel differences and squares
    always_comb begin
        d_b = (s1_pix_reg.blue >= rd_reg.blue) ? s1_pix_reg.blue - rd_reg.blue
                                               : rd_reg.blue - s1_pix_reg.blue;
        d_g = (s1_pix_reg.green >= rd_reg.green) ? s1_pix_reg.green - rd_reg.green
                                                 : rd_reg.green - s1_pix_reg.green;
        d_r = (s1_pix_reg.red >= rd_reg.red) ? s1_pix_reg.red - rd_reg.red
                                             : rd_reg.red - s1_pix_reg.red;
        sq_b_next = SQ_W'(d_b) * SQ_W'(d_b);
        sq_g_next = SQ_W'(d_g) * SQ_W'(d_g);
        sq_r_next = SQ_W'(d_r) * SQ_W'(d_r);
    end

    // running best over this cell's entries; strict compare keeps the lowest index
    always_comb begin
        sum = DIST_W'(sq_b_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_r_reg);
        base_valid      = s2_ctl_reg.first ? 1'b0 : best_valid_reg;
        best_valid_next = best_valid_reg;
        best_dist_next  = best_dist_reg;
        best_idx_next   = best_idx_reg;
        if (s2_ctl_reg.valid) begin
            best_valid_next = base_valid;
            if (s2_hit_reg && (!base_valid || sum < best_dist_reg)) begin
                best_valid_next = 1'b1;
                best_dist_next  = sum;
                best_idx_next   = s2_idx_reg;
            end
        end
    end

    // merge with the upstream best; ties go to the lower index
    always_comb begin
        take_local = best_valid_reg &&
                     (!red_in.valid || best_dist_reg < red_in.score ||
                      (best_dist_reg == red_in.score && best_idx_reg < red_idx_in));
        red_out_next.done = s3_last_reg;
        if (take_local) begin
            red_out_next.valid = 1'b1;
            red_out_next.score = best_dist_reg;
            red_idx_out_next   = best_idx_reg;
        end else begin
            red_out_next.valid = red_in.valid;
            red_out_next.score = red_in.score;
            red_idx_out_next   = red_idx_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_out_reg    <= '0;
            s1_ctl_reg     <= '0;
            s1_hit_reg     <= 1'b0;
            s2_ctl_reg     <= '0;
            s2_hit_reg     <= 1'b0;
            best_valid_reg <= 1'b0;
            s3_last_reg    <= 1'b0;
            red_out_reg    <= '0;
        end else begin
            ctl_out_reg    <= ctl_in;
            s1_ctl_reg     <= ctl_in;
            s1_hit_reg     <= ctl_in.valid && (entry_idx < count_in);
            s2_ctl_reg     <= s1_ctl_reg;
            s2_hit_reg     <= s1_hit_reg;
            best_valid_reg <= best_valid_next;
            s3_last_reg    <= s2_ctl_reg.valid && s2_ctl_reg.last;
            if (s3_last_reg) begin
                red_out_reg <= red_out_next;
            end else begin
                red_out_reg.done <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        row_out_reg   <= row_in;
        pix_out_reg   <= pix_in;
        s1_idx_reg    <= entry_idx;
        s1_pix_reg    <= pix_in;
        s2_idx_reg    <= s1_idx_reg;
        sq_b_reg      <= sq_b_next;
        sq_g_reg      <= sq_g_next;
        sq_r_reg      <= sq_r_next;
        best_dist_reg <= best_dist_next;
        best_idx_reg  <= best_idx_next;
        if (s3_last_reg) begin
            red_idx_out_reg <= red_idx_out_next;
        end
    end

    assign ctl_out     = ctl_out_reg;
    assign row_out     = row_out_reg;
    assign pix_out     = pix_out_reg;
    assign red_out     = red_out_reg;
    assign red_idx_out = red_idx_out_reg;

    a_hit_needs_token: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_hit_reg |-> s1_ctl_reg.valid)
        else $error("entry hit without a scan token");

    a_reduce_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        red_in.done |-> s3_last_reg)
        else $error("upstream best arrived out of step with local scan end");

    a_done_has_best: assert property (@(posedge aclk) disable iff (!aresetn)
        red_out_reg.done |-> red_out_reg.valid)
        else $error("reduction finished without a candidate");

endmodule
